@@ hw/rtl/fvdp_pkg.sv @@
// Shared constants and types for the four-lane binary32 dot product.
// Used by the interface, multiply-add, lane, reduction and top-level files.
package fvdp_pkg;

  localparam int LANES = 4;
  localparam int FP_W  = 32;

  localparam logic [FP_W-1:0] FP_ZERO   = 32'h0000_0000;
  localparam logic [FP_W-1:0] FP_ONE    = 32'h3F80_0000;
  localparam logic [FP_W-1:0] FP_QNAN   = 32'h7FC0_0000;
  localparam logic [FP_W-1:0] FP_INF    = 32'h7F80_0000;

  // Four lane sums handed from the lane multiply-add units to the reduction tree.
  typedef struct packed {
    logic [LANES-1:0][FP_W-1:0] sum;
  } lane_grp_t;

endpackage

@@ hw/rtl/fvdp_if.sv @@
// Valid/ready channel interfaces for the dot product block.
// Depends on fvdp_pkg for the word width.
interface fvdp_in_if;
  logic                    valid;
  logic                    ready;
  logic [fvdp_pkg::FP_W-1:0] a_lane0;
  logic [fvdp_pkg::FP_W-1:0] a_lane1;
  logic [fvdp_pkg::FP_W-1:0] a_lane2;
  logic [fvdp_pkg::FP_W-1:0] a_lane3;
  logic [fvdp_pkg::FP_W-1:0] b_lane0;
  logic [fvdp_pkg::FP_W-1:0] b_lane1;
  logic [fvdp_pkg::FP_W-1:0] b_lane2;
  logic [fvdp_pkg::FP_W-1:0] b_lane3;
  logic                    last_group;

  modport source (output valid, a_lane0, a_lane1, a_lane2, a_lane3,
                  b_lane0, b_lane1, b_lane2, b_lane3, last_group, input ready);
  modport sink   (input valid, a_lane0, a_lane1, a_lane2, a_lane3,
                  b_lane0, b_lane1, b_lane2, b_lane3, last_group, output ready);
endinterface

interface fvdp_out_if;
  logic                    valid;
  logic                    ready;
  logic [fvdp_pkg::FP_W-1:0] dot_value;

  modport source (output valid, dot_value, input ready);
  modport sink   (input valid, dot_value, output ready);
endinterface

@@ hw/rtl/float_vector_dot_product_top.sv @@
// Top level of the four-lane binary32 dot product.
// Depends on fvdp_pkg, fvdp_if, fvdp_lanes and fvdp_reduce.
//
//   Channel  Dir  Handshake          Contents
//   in_ch    in   valid/ready        a_lane0..3, b_lane0..3, last_group
//   out_ch   out  valid/ready        dot_value
//
// One element group is taken per cycle; each lane does one fused multiply-add
// per cycle, which is the loop that sets that rate.
// A closing group is reduced through the stages into the output register.
// Reset is synchronous and clears the accumulators to positive zero.
// A stalled output holds its result; groups that do not close a vector are
// still taken, and a closing group waits in the input register, stalling the
// input, once the reduction stages and output register behind it are full.
module float_vector_dot_product_top (
  input logic        clk,
  input logic        rst_n,
  fvdp_in_if.sink    in_ch,
  fvdp_out_if.source out_ch
);
  import fvdp_pkg::*;

  logic      grp_valid;
  logic      grp_ready;
  lane_grp_t grp;

  fvdp_lanes u_lanes (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  fvdp_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .out_ch    (out_ch)
  );

endmodule

@@ hw/rtl/fvdp_fma.sv @@
// Combinational binary32 fused multiply-add, round to nearest even.
// Depends on fvdp_pkg for special-value constants.
module fvdp_fma (
  input  logic [fvdp_pkg::FP_W-1:0] a,
  input  logic [fvdp_pkg::FP_W-1:0] b,
  input  logic [fvdp_pkg::FP_W-1:0] c,
  output logic [fvdp_pkg::FP_W-1:0] y
);
  import fvdp_pkg::*;

  // Count of leading zeros in a 64-bit word.
  function automatic logic [6:0] clz64(input logic [63:0] v);
    logic [6:0] n;
    logic       found;
    n     = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 7'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round the nonzero value r * 2^e to binary32 with the given sign.
  function automatic logic [31:0] round_pack(input logic sign, input logic [63:0] r,
                                             input logic signed [12:0] e);
    logic signed [12:0] t;
    logic signed [12:0] be;
    logic signed [12:0] s;
    logic signed [12:0] ns;
    logic [63:0]        m;
    logic [63:0]        rem;
    logic [63:0]        half;
    logic [5:0]         sh;
    logic [31:0]        res;
    t  = 13'sd63 - $signed({6'b0, clz64(r)});
    be = t + e + 13'sd127;
    s  = t - 13'sd23;
    if (be < 13'sd1) begin
      s  = s + (13'sd1 - be);
      be = 13'sd1;
    end
    ns   = -s;
    sh   = s[5:0];
    rem  = '0;
    half = '0;
    if (s <= 13'sd0) begin
      m = r << ns[5:0];
    end else if (s >= 13'sd64) begin
      m = '0;
    end else begin
      rem  = r & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 6'd1);
      m    = r >> sh;
      if (rem > half || (rem == half && m[0])) begin
        m = m + 64'd1;
      end
    end
    // Rounding carried into a new binade.
    if (m[24]) begin
      m  = m >> 1;
      be = be + 13'sd1;
    end
    if (be >= 13'sd255) begin
      res = {sign, FP_INF[30:0]};
    end else begin
      if (!m[23]) begin
        be = '0;
      end
      res = {sign, be[7:0], m[22:0]};
    end
    return res;
  endfunction

  logic ps, cs;
  logic a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
  logic [23:0] ma, mb, mc;
  logic signed [12:0] xa, xb, xc, ep, ec, eb, es, gap;
  logic [63:0] mp, mcn, big, minor, lost, r;
  logic [6:0] lzp, lzc;
  logic bsign, ssign;

  always_comb begin
    ps     = a[31] ^ b[31];
    cs     = c[31];
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    c_nan  = (c[30:23] == 8'hFF) && (c[22:0] != '0);
    a_inf  = (a[30:0] == FP_INF[30:0]);
    b_inf  = (b[30:0] == FP_INF[30:0]);
    c_inf  = (c[30:0] == FP_INF[30:0]);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    c_zero = (c[30:0] == '0);

    // Unpack to integer significand and exponent of its last bit.
    ma = {(a[30:23] != '0), a[22:0]};
    mb = {(b[30:23] != '0), b[22:0]};
    mc = {(c[30:23] != '0), c[22:0]};
    xa = (a[30:23] == '0) ? -13'sd149 : $signed({5'b0, a[30:23]}) - 13'sd150;
    xb = (b[30:23] == '0) ? -13'sd149 : $signed({5'b0, b[30:23]}) - 13'sd150;
    xc = (c[30:23] == '0) ? -13'sd149 : $signed({5'b0, c[30:23]}) - 13'sd150;

    // Exact product, normalized so the leading one sits at bit 61.
    mp  = {16'b0, 48'(ma) * 48'(mb)};
    lzp = clz64(mp);
    mp  = mp << (lzp - 7'd2);
    ep  = xa + xb - ($signed({6'b0, lzp}) - 13'sd2);

    mcn = {40'b0, mc};
    lzc = clz64(mcn);
    mcn = mcn << (lzc - 7'd2);
    ec  = xc - ($signed({6'b0, lzc}) - 13'sd2);

    // Order by magnitude.
    if (ep > ec || (ep == ec && mp >= mcn)) begin
      big = mp;  eb = ep; bsign = ps; minor = mcn; es = ec; ssign = cs;
    end else begin
      big = mcn; eb = ec; bsign = cs; minor = mp;  es = ep; ssign = ps;
    end

    // Align the smaller term, folding shifted-out bits into a sticky bit.
    gap  = eb - es;
    lost = '0;
    if (gap >= 13'sd63) begin
      minor = {63'b0, (minor != '0)};
    end else if (gap > 13'sd0) begin
      lost  = minor & ((64'd1 << gap[5:0]) - 64'd1);
      minor = (minor >> gap[5:0]) | {63'b0, (lost != '0)};
    end
    r = (bsign == ssign) ? big + minor : big - minor;

    // Special operands take priority over the datapath result.
    if (a_nan || b_nan || c_nan) begin
      y = FP_QNAN;
    end else if (a_inf || b_inf) begin
      if (a_zero || b_zero) begin
        y = FP_QNAN;
      end else if (c_inf && cs != ps) begin
        y = FP_QNAN;
      end else begin
        y = {ps, FP_INF[30:0]};
      end
    end else if (c_inf) begin
      y = c;
    end else if (a_zero || b_zero) begin
      y = c_zero ? {(ps & cs), 31'b0} : c;
    end else if (c_zero) begin
      y = round_pack(ps, mp, ep);
    end else if (r == '0) begin
      y = FP_ZERO;
    end else begin
      y = round_pack(bsign, r, eb);
    end
  end

endmodule

@@ hw/rtl/fvdp_lanes.sv @@
// Input register and four lane accumulators with one fused multiply-add each.
// Depends on fvdp_pkg, fvdp_if and fvdp_fma.
module fvdp_lanes (
  input  logic                clk,
  input  logic                rst_n,
  fvdp_in_if.sink             in_ch,
  output logic                grp_valid,
  input  logic                grp_ready,
  output fvdp_pkg::lane_grp_t grp
);
  import fvdp_pkg::*;

  logic                 in_v_r, in_v_nxt;
  logic [FP_W-1:0]      a_r [LANES];
  logic [FP_W-1:0]      b_r [LANES];
  logic                 last_r;
  logic [FP_W-1:0]      acc_r [LANES];
  logic [FP_W-1:0]      fma_y [LANES];
  logic                 fire;
  logic                 take;

  // A held group moves on unless it closes a vector and the tree is full.
  assign fire         = in_v_r && (!last_r || grp_ready);
  assign in_ch.ready  = !in_v_r || fire;
  assign take         = in_ch.valid && in_ch.ready;
  assign in_v_nxt     = take ? 1'b1 : (fire ? 1'b0 : in_v_r);
  assign grp_valid    = in_v_r && last_r;

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      a_r[0] <= in_ch.a_lane0;
      a_r[1] <= in_ch.a_lane1;
      a_r[2] <= in_ch.a_lane2;
      a_r[3] <= in_ch.a_lane3;
      b_r[0] <= in_ch.b_lane0;
      b_r[1] <= in_ch.b_lane1;
      b_r[2] <= in_ch.b_lane2;
      b_r[3] <= in_ch.b_lane3;
      last_r <= in_ch.last_group;
    end
  end

  // One multiply-add unit per lane, feeding its own accumulator.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    fvdp_fma u_fma (
      .a (a_r[i]),
      .b (b_r[i]),
      .c (acc_r[i]),
      .y (fma_y[i])
    );

    assign grp.sum[i] = fma_y[i];

    // The accumulator clears once the closing group has been handed on.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[i] <= FP_ZERO;
      end else if (fire) begin
        acc_r[i] <= last_r ? FP_ZERO : fma_y[i];
      end
    end
  end

endmodule

@@ hw/rtl/fvdp_reduce.sv @@
// Three-stage sum of the lane results, ((l0+l1)+l2)+l3, and the output register.
// Depends on fvdp_pkg, fvdp_if and fvdp_fma.
module fvdp_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_valid,
  output logic                grp_ready,
  input  fvdp_pkg::lane_grp_t grp,
  fvdp_out_if.source          out_ch
);
  import fvdp_pkg::*;

  logic            s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic [FP_W-1:0] s1_l_r [LANES];
  logic [FP_W-1:0] s2_t_r, s2_l2_r, s2_l3_r;
  logic [FP_W-1:0] s3_t_r, s3_l3_r;
  logic [FP_W-1:0] dot_r;
  logic [FP_W-1:0] add1_y, add2_y, add3_y;
  logic            adv_o, adv3, adv2, adv1;

  // Each stage takes new data when it is empty or its content moves on.
  assign adv_o     = !out_v_r || out_ch.ready;
  assign adv3      = !s3_v_r || adv_o;
  assign adv2      = !s2_v_r || adv3;
  assign adv1      = !s1_v_r || adv2;
  assign grp_ready = adv1;

  fvdp_fma u_add1 (.a(s1_l_r[0]), .b(FP_ONE), .c(s1_l_r[1]), .y(add1_y));
  fvdp_fma u_add2 (.a(s2_t_r),    .b(FP_ONE), .c(s2_l2_r),   .y(add2_y));
  fvdp_fma u_add3 (.a(s3_t_r),    .b(FP_ONE), .c(s3_l3_r),   .y(add3_y));

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r  <= grp_valid;
      if (adv2) s2_v_r  <= s1_v_r;
      if (adv3) s3_v_r  <= s2_v_r;
      if (adv_o) out_v_r <= s3_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < LANES; i++) s1_l_r[i] <= grp.sum[i];
    end
    if (adv2) begin
      s2_t_r  <= add1_y;
      s2_l2_r <= s1_l_r[2];
      s2_l3_r <= s1_l_r[3];
    end
    if (adv3) begin
      s3_t_r  <= add2_y;
      s3_l3_r <= s2_l3_r;
    end
    if (adv_o) begin
      dot_r <= add3_y;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.dot_value = dot_r;

endmodule

@@ hw/rtl/fvdp_checker.sv @@
// Port-level checks for the dot product top level, bound to it below.
// Depends on fvdp_if and float_vector_dot_product_top.
module fvdp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_dot
);

  // A result offered and not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_dot))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Input backpressure only arises from a stalled output.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind float_vector_dot_product_top fvdp_checker u_fvdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_dot   (out_ch.dot_value)
);

@@ sim/tb_float_vector_dot_product_top.sv @@
// Self-checking testbench for the four-lane binary32 dot product block.
// Depends on fvdp_pkg, fvdp_if and float_vector_dot_product_top from the RTL.
module tb_float_vector_dot_product_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fvdp_pkg::*;

  typedef logic [FP_W-1:0] word_t;

  typedef struct {
    word_t a [LANES];
    word_t b [LANES];
    logic  last;
    logic  known;   // expected value typed in for this row
    word_t dot;
  } group_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fvdp_in_if  in_ch ();
  fvdp_out_if out_ch ();

  float_vector_dot_product_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #1 clk = ~clk;

  // Predicted lane accumulators and the queue of expected dot products.
  word_t acc [LANES];
  word_t dot_queue [$];
  int    error_count = 0;
  bit    stim_done = 0;
  bit    quiet_phase = 0;

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("mismatch: %s got %08h expected %08h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic bit is_nan(word_t x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic bit is_inf(word_t x);
    return x[30:0] == 31'h7F80_0000;
  endfunction

  function automatic bit is_zero(word_t x);
    return x[30:0] == 0;
  endfunction

  function automatic int msb_pos(logic [63:0] v);
    for (int i = 63; i >= 0; i--) if (v[i]) return i;
    return -1;
  endfunction

  // Round the nonzero value r * 2^e to binary32, nearest-even.
  function automatic word_t round_to_single(logic sgn, logic [63:0] r, int e);
    int t, be, s;
    logic [63:0] m, rem, half;
    t = msb_pos(r);
    be = t + e + 127;
    s = t - 23;
    if (be < 1) begin
      s += 1 - be;
      be = 1;
    end
    if (s <= 0) begin
      m = r << (-s);
    end else if (s >= 64) begin
      m = 0;
    end else begin
      rem = r & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      m = r >> s;
      if (rem > half || (rem == half && m[0])) m++;
    end
    if (m >> 24) begin
      m >>= 1;
      be++;
    end
    if (be >= 255) return {sgn, FP_INF[30:0]};
    if (m < 64'h80_0000) be = 0;
    return {sgn, be[7:0], m[22:0]};
  endfunction

  // Split a finite value into an integer significand and exponent.
  function automatic void split_float(input word_t x, output logic [63:0] m, output int e);
    if (x[30:23] == 0) begin
      m = {41'd0, x[22:0]};
      e = -149;
    end else begin
      m = {40'd0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  // Fused multiply-add with a single rounding.
  function automatic word_t fused_mac(word_t a, word_t b, word_t c);
    logic ps, cs, bs, ss;
    logic [63:0] ma, mb, mc, mp, big, lil, lost, r;
    int xa, xb, xc, ep, ec, eb, es, d;
    ps = a[31] ^ b[31];
    cs = c[31];
    if (is_nan(a) || is_nan(b) || is_nan(c)) return FP_QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (is_zero(a) || is_zero(b)) return FP_QNAN;
      if (is_inf(c) && cs != ps) return FP_QNAN;
      return {ps, FP_INF[30:0]};
    end
    if (is_inf(c)) return c;
    if (is_zero(a) || is_zero(b)) begin
      if (is_zero(c)) return {ps & cs, 31'd0};
      return c;
    end
    split_float(a, ma, xa);
    split_float(b, mb, xb);
    mp = ma * mb;
    d = 61 - msb_pos(mp);
    mp <<= d;
    ep = xa + xb - d;
    if (is_zero(c)) return round_to_single(ps, mp, ep);
    split_float(c, mc, xc);
    d = 61 - msb_pos(mc);
    mc <<= d;
    ec = xc - d;
    if (ep > ec || (ep == ec && mp >= mc)) begin
      big = mp; eb = ep; bs = ps; lil = mc; es = ec; ss = cs;
    end else begin
      big = mc; eb = ec; bs = cs; lil = mp; es = ep; ss = ps;
    end
    d = eb - es;
    if (d >= 63) begin
      lil = (lil != 0) ? 64'd1 : 64'd0;
    end else if (d > 0) begin
      lost = lil & ((64'd1 << d) - 1);
      lil = (lil >> d) | ((lost != 0) ? 64'd1 : 64'd0);
    end
    if (bs == ss) begin
      r = big + lil;
    end else begin
      r = big - lil;
      if (r == 0) return FP_ZERO;
    end
    return round_to_single(bs, r, eb);
  endfunction

  // Advance the predicted lanes by one group; queue a dot product on the last one.
  task automatic predict_group(input group_t g);
    word_t s;
    for (int i = 0; i < LANES; i++) acc[i] = fused_mac(g.a[i], g.b[i], acc[i]);
    if (g.last) begin
      s = fused_mac(acc[0], FP_ONE, acc[1]);
      s = fused_mac(s, FP_ONE, acc[2]);
      s = fused_mac(s, FP_ONE, acc[3]);
      if (g.known && s !== g.dot) report_mismatch("predictor vs typed row", s, g.dot);
      dot_queue.push_back(g.known ? g.dot : s);
      for (int i = 0; i < LANES; i++) acc[i] = FP_ZERO;
    end
  endtask

  // Random binary32 pattern, biased toward interesting classes.
  function automatic word_t random_float();
    word_t x;
    x = $urandom;
    case ($urandom_range(0, 19))
      0: x[30:23] = 8'hFF;
      1: x[30:23] = 8'h00;
      2: x[30:0] = 0;
      3: x[30:23] = 8'hFE;
      default: x[30:23] = 8'd110 + 8'($urandom_range(0, 34));
    endcase
    return x;
  endfunction

  function automatic group_t make_group(word_t a0, word_t b0, logic last, logic known, word_t dot);
    group_t g;
    for (int i = 0; i < LANES; i++) begin
      g.a[i] = FP_ZERO;
      g.b[i] = FP_ZERO;
    end
    g.a[0] = a0;
    g.b[0] = b0;
    g.last = last;
    g.known = known;
    g.dot = dot;
    return g;
  endfunction

  // Directed table: extremes, NaN rules, signed zeros, subnormals, overflow.
  group_t directed [$];

  task automatic build_table();
    group_t g;
    directed.push_back(make_group(FP_ONE, FP_ONE, 1'b1, 1'b1, FP_ONE));
    directed.push_back(make_group(32'h8000_0000, FP_ONE, 1'b1, 1'b1, FP_ZERO));
    directed.push_back(make_group(FP_INF, FP_ZERO, 1'b1, 1'b1, FP_QNAN));
    directed.push_back(make_group(32'h7F80_0001, FP_ONE, 1'b1, 1'b1, FP_QNAN));
    directed.push_back(make_group(32'hFFFF_FFFF, FP_ONE, 1'b1, 1'b1, FP_QNAN));
    directed.push_back(make_group(32'h7F7F_FFFF, 32'h4000_0000, 1'b1, 1'b1, FP_INF));
    directed.push_back(make_group(32'hFF7F_FFFF, 32'h4000_0000, 1'b1, 1'b1, 32'hFF80_0000));
    directed.push_back(make_group(32'h0000_0001, 32'h3F00_0000, 1'b1, 1'b1, FP_ZERO));
    directed.push_back(make_group(32'h0000_0001, FP_ONE, 1'b1, 1'b1, 32'h0000_0001));
    // Infinities of opposite sign in different lanes meet in the reduction.
    g = make_group(FP_INF, FP_ONE, 1'b0, 1'b0, FP_ZERO);
    g.a[1] = 32'hFF80_0000;
    g.b[1] = FP_ONE;
    directed.push_back(g);
    directed.push_back(make_group(FP_ZERO, FP_ZERO, 1'b1, 1'b1, FP_QNAN));
    // Exact cancellation across lanes gives positive zero.
    g = make_group(FP_ONE, FP_ONE, 1'b1, 1'b1, FP_ZERO);
    g.a[1] = 32'hBF80_0000;
    g.b[1] = FP_ONE;
    directed.push_back(g);
    // Multi-group vector with full lanes, then one group of NaN patterns in every lane.
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < LANES; i++) begin
        g.a[i] = 32'h4040_0000 ^ (k << 20);
        g.b[i] = 32'hC0A0_0000 | i;
      end
      g.last = (k == 2);
      g.known = 1'b0;
      directed.push_back(g);
    end
    for (int i = 0; i < LANES; i++) begin
      g.a[i] = 32'h7FFF_FFFF;
      g.b[i] = 32'h0000_0000;
    end
    g.last = 1'b1;
    directed.push_back(g);
    directed.push_back(make_group(32'h0080_0000, 32'h3F7F_FFFF, 1'b1, 1'b0, FP_ZERO));
    directed.push_back(make_group(32'h1234_5678, 32'hEDCB_A987, 1'b1, 1'b0, FP_ZERO));
  endtask

  // Offer one group and wait until the block accepts it.
  task automatic send_group(input group_t g);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_lane0 <= g.a[0];
    in_ch.a_lane1 <= g.a[1];
    in_ch.a_lane2 <= g.a[2];
    in_ch.a_lane3 <= g.a[3];
    in_ch.b_lane0 <= g.b[0];
    in_ch.b_lane1 <= g.b[1];
    in_ch.b_lane2 <= g.b[2];
    in_ch.b_lane3 <= g.b[3];
    in_ch.last_group <= g.last;
    do @(posedge clk); while (!in_ch.ready);
    predict_group(g);
  endtask

  // Stimulus: directed table, then random vectors of 1 to 6 groups.
  initial begin
    group_t g;
    int sent, len;
    in_ch.valid = 1'b0;
    in_ch.a_lane0 = '0;
    in_ch.a_lane1 = '0;
    in_ch.a_lane2 = '0;
    in_ch.a_lane3 = '0;
    in_ch.b_lane0 = '0;
    in_ch.b_lane1 = '0;
    in_ch.b_lane2 = '0;
    in_ch.b_lane3 = '0;
    in_ch.last_group = 1'b0;
    for (int i = 0; i < LANES; i++) acc[i] = FP_ZERO;
    build_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[r]) send_group(directed[r]);
    sent = 0;
    while (sent < 400) begin
      len = $urandom_range(1, 6);
      if (sent > 320) quiet_phase = 1;
      for (int k = 0; k < len; k++) begin
        for (int i = 0; i < LANES; i++) begin
          g.a[i] = random_float();
          g.b[i] = random_float();
        end
        g.last = (k == len - 1);
        g.known = 1'b0;
        send_group(g);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stalls, plus one long hold-off so the input backs up.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    repeat (40) @(posedge clk);
    out_ch.ready <= 1'b0;
    repeat (60) @(posedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (dot_queue.size() == 0) begin
        report_mismatch("unexpected result", out_ch.dot_value, 'x);
      end else begin
        if (out_ch.dot_value !== dot_queue[0])
          report_mismatch("dot_value", out_ch.dot_value, dot_queue[0]);
        void'(dot_queue.pop_front());
      end
    end
  end

  // End of run: drain, allow the pipeline to settle, then judge.
  initial begin
    wait (stim_done);
    while (dot_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

endmodule
